// File: src/assert_macros.svh
// assertion macros shared by the checker files
// needs nothing else; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bamc_pkg.sv
// types and constants for the best alignment match counter
// used by the controller, the datapath, the top level and the checker
`default_nettype none

package bamc_pkg;

  localparam int FC_W      = 7;
  localparam int BEST_W    = 6;
  localparam int SCORE_W   = 22;
  localparam int FRAC_BITS = 16;

  localparam logic [FC_W-1:0]    FULL_COUNT_RESET = 7'd5;
  localparam logic [SCORE_W-1:0] SCORE_SAT        = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_AG    = 2'd1,
    ACT_AB    = 2'd2,
    ACT_EVAL  = 2'd3
  } action_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// File: src/best_alignment_match_counter.sv
// channel   | direction | payload                              | handshake
// request   | in        | action, symbol                       | req_valid / req_stall
// result    | out       | best_matches, score, overflowed      | res_valid / res_stall
// config    | in        | cfg_data (full_count)                | cfg_write
//
// clear and append requests leave the controller idle, so the request channel does not stall.
// evaluate reads one symbol pair per cycle through the two store read ports, over every
// shift and position of ls/lf, the shorter/longer lengths, then takes one quotient bit
// per cycle from the divider (22 bits at MAX_LEN = 32).
// synchronous reset clears lengths and overflow flag, drops res_valid and stalls requests; full_count goes to 5.
// a stalled result holds; an appending request is taken while a result waits.
//
// top level of the best alignment match counter; needs bamc_pkg, bamc_ctrl, bamc_dp
`default_nettype none

module best_alignment_match_counter #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [bamc_pkg::FC_W-1:0]     cfg_data,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [1:0]                    action,
  input  wire logic [7:0]                    symbol,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic [bamc_pkg::BEST_W-1:0]        best_matches,
  output logic [bamc_pkg::SCORE_W-1:0]       score,
  output logic                               overflowed
);

  bamc_pkg::cmd_t    cmd;
  bamc_pkg::status_t status;

  bamc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .status    (status)
  );

  bamc_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .symbol       (symbol),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .best_matches (best_matches),
    .score        (score),
    .overflowed   (overflowed)
  );

endmodule

`default_nettype wire

// File: src/bamc_dp.sv
// datapath: symbol stores, alignment scan with match counting, restoring divider
// and result registers; driven by bamc_ctrl through bamc_pkg command/status structs
`default_nettype none

module bamc_dp #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [1:0]                   action,
  input  wire logic [7:0]                   symbol,
  input  wire logic                         cfg_write,
  input  wire logic [bamc_pkg::FC_W-1:0]    cfg_data,
  input  wire bamc_pkg::cmd_t               cmd,
  output bamc_pkg::status_t                 status,
  output logic [bamc_pkg::BEST_W-1:0]       best_matches,
  output logic [bamc_pkg::SCORE_W-1:0]      score,
  output logic                              overflowed
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW  = LW + 1;
  localparam int PW  = $clog2(3 * MAX_LEN);
  localparam int QW  = LW + bamc_pkg::FRAC_BITS;
  localparam int RW  = bamc_pkg::FC_W + 1;
  localparam int DCW = $clog2(QW);

  localparam logic [LW-1:0]  LEN_MAX  = LW'(MAX_LEN);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(QW - 1);

  logic [7:0] antigen_mem  [MAX_LEN];
  logic [7:0] antibody_mem [MAX_LEN];

  logic [LW-1:0]                antigen_len;
  logic [LW-1:0]                antibody_len;
  logic                         ovf;
  logic [bamc_pkg::FC_W-1:0]    full_count;

  logic                         sel_ag;
  logic [LW-1:0]                ls;
  logic [LW-1:0]                lf;
  logic [SW-1:0]                shift;
  logic [AW-1:0]                k;
  logic [AW-1:0]                klast;
  logic [SW-1:0]                shift_last;
  logic [PW-1:0]                pos;
  logic [PW-1:0]                fpos;
  logic                         in_range;
  logic [AW-1:0]                ag_addr;
  logic [AW-1:0]                ab_addr;

  logic [7:0]                   ag_q;
  logic [7:0]                   ab_q;
  logic                         p_valid;
  logic                         p_range;
  logic                         p_first;
  logic                         p_last;
  logic                         hit;
  logic [LW-1:0]                count;
  logic [LW-1:0]                count_next;
  logic [LW-1:0]                best;

  logic [QW-1:0]                quot;
  logic [RW-1:0]                rem;
  logic [RW-1:0]                rem_sh;
  logic                         rem_ge;
  logic [DCW-1:0]               dcnt;

  // scan addressing
  assign klast      = (ls == '0) ? '0 : AW'(ls - LW'(1));
  assign shift_last = SW'(lf) + SW'(ls);
  assign pos        = PW'(shift) + PW'(k);
  assign fpos       = pos - PW'(ls);
  assign in_range   = (LW'(k) < ls) && (pos >= PW'(ls)) && (fpos < PW'(lf));
  assign ag_addr    = sel_ag ? k : AW'(fpos);
  assign ab_addr    = sel_ag ? AW'(fpos) : k;

  assign status.scan_last = (shift == shift_last) && (k == klast);
  assign status.div_last  = (dcnt == DIV_LAST);

  assign hit        = p_range && (ag_q == ab_q);
  assign count_next = (p_first ? '0 : count) + LW'(hit);

  assign rem_sh = {rem[RW-2:0], quot[QW-1]};
  assign rem_ge = (rem_sh >= RW'(full_count));

  // stores
  always_ff @(posedge clk) begin
    if (cmd.load && (action == bamc_pkg::ACT_AG) && (antigen_len < LEN_MAX)) begin
      antigen_mem[antigen_len[AW-1:0]] <= symbol;
    end
    if (cmd.load && (action == bamc_pkg::ACT_AB) && (antibody_len < LEN_MAX)) begin
      antibody_mem[antibody_len[AW-1:0]] <= symbol;
    end
    ag_q <= antigen_mem[ag_addr];
    ab_q <= antibody_mem[ab_addr];
  end

  // lengths, overflow flag and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      antigen_len  <= '0;
      antibody_len <= '0;
      ovf          <= 1'b0;
      full_count   <= bamc_pkg::FULL_COUNT_RESET;
    end else begin
      if (cfg_write) begin
        full_count <= cfg_data;
      end
      if (cmd.load) begin
        case (action)
          bamc_pkg::ACT_CLEAR: begin
            antigen_len  <= '0;
            antibody_len <= '0;
            ovf          <= 1'b0;
          end
          bamc_pkg::ACT_AG: begin
            if (antigen_len < LEN_MAX) begin
              antigen_len <= antigen_len + LW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          bamc_pkg::ACT_AB: begin
            if (antibody_len < LEN_MAX) begin
              antibody_len <= antibody_len + LW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.scan_step;
    end
  end

  // scan counters and compare pipeline
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      // antigen slides when lengths are equal
      sel_ag <= (antigen_len <= antibody_len);
      ls     <= (antigen_len <= antibody_len) ? antigen_len : antibody_len;
      lf     <= (antigen_len <= antibody_len) ? antibody_len : antigen_len;
      shift  <= '0;
      k      <= '0;
    end else if (cmd.scan_step) begin
      if (k == klast) begin
        k     <= '0;
        shift <= shift + SW'(1);
      end else begin
        k <= k + AW'(1);
      end
    end
    p_range <= in_range;
    p_first <= (k == '0);
    p_last  <= (k == klast);
    if (cmd.scan_start) begin
      best <= '0;
    end else if (p_valid) begin
      count <= count_next;
      if (p_last && (count_next > best)) begin
        best <= count_next;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot <= {best, {bamc_pkg::FRAC_BITS{1'b0}}};
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[QW-2:0], rem_ge};
      rem  <= rem_ge ? (rem_sh - RW'(full_count)) : rem_sh;
      dcnt <= dcnt + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      best_matches <= bamc_pkg::BEST_W'(best);
      score        <= (full_count == '0) ? bamc_pkg::SCORE_SAT : bamc_pkg::SCORE_W'(quot);
      overflowed   <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: src/bamc_ctrl.sv
// controller state machine: request handshake, scan/divide sequencing, result valid
// uses bamc_pkg command/status structs; drives bamc_dp
`default_nettype none

module bamc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [1:0]        action,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output bamc_pkg::cmd_t         cmd,
  input  wire bamc_pkg::status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (action == bamc_pkg::ACT_EVAL) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_stall <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != ST_IDLE);
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bamc_checker.sv
// port-level checker for the best alignment match counter, bound to the top level
// needs bamc_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bamc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_stall,
  input wire logic [1:0]                    action,
  input wire logic                          res_valid,
  input wire logic                          res_stall,
  input wire logic [bamc_pkg::BEST_W-1:0]   best_matches,
  input wire logic [bamc_pkg::SCORE_W-1:0]  score,
  input wire logic                          overflowed
);

  logic req_take;
  logic eval_take;

  assign req_take   = req_valid && !req_stall;
  assign eval_take  = req_take && (action == bamc_pkg::ACT_EVAL);

  `CHK_NEXT(a_res_hold, clk, rst, res_valid && res_stall,
            res_valid && $stable(best_matches) && $stable(score) && $stable(overflowed),
            "stalled result changed")

  `CHK_NEXT(a_eval_busy, clk, rst, eval_take, req_stall,
            "evaluate request did not stall the request channel")

  `CHK_NEXT(a_append_free, clk, rst, req_take && !eval_take, !req_stall,
            "request channel stalled after a one-cycle request")

  `CHK_IMPL(a_res_after_work, clk, rst, $rose(res_valid), $past(req_stall),
            "result appeared without an evaluate in progress")

endmodule

bind best_alignment_match_counter bamc_checker u_bamc_checker (.*);

`default_nettype wire
